// ===== src/q4dp_pkg.sv =====
// Package for the 4-bit block-quantized dot product.
// Holds the block-end entry type, queue depths, saturation limits and the pair product.
// No dependencies.
`default_nettype none

package q4dp_pkg;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 2;

  localparam logic signed [12:0] BSUM_MAX = 13'sd4095;
  localparam logic signed [12:0] BSUM_MIN = -13'sd4096;

  typedef struct packed {
    logic signed [12:0] sum;
    logic signed [15:0] a_scale;
    logic signed [15:0] b_scale;
    logic               row_end;
  } blk_entry_t;

  // each nibble decodes as nibble - 8, which is the nibble with its top bit flipped
  function automatic logic signed [8:0] pair_product(logic [7:0] a, logic [7:0] b);
    logic signed [3:0] al;
    logic signed [3:0] ah;
    logic signed [3:0] bl;
    logic signed [3:0] bh;
    logic signed [7:0] pl;
    logic signed [7:0] ph;
    al = signed'({~a[3], a[2:0]});
    ah = signed'({~a[7], a[6:4]});
    bl = signed'({~b[3], b[2:0]});
    bh = signed'({~b[7], b[6:4]});
    pl = al * bl;
    ph = ah * bh;
    return 9'(pl) + 9'(ph);
  endfunction

endpackage

`default_nettype wire

// ===== src/q4dp_fifo.sv =====
// Small first-in first-out queue of registers with a combinational head.
// Used between front and back and on the result side; no package needed.
`default_nettype none

module q4dp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/q4dp_front.sv =====
// Front end: decodes byte pairs and keeps the saturating block integer sum.
// Emits one blk_entry_t per block or row end. Depends on q4dp_pkg.
`default_nettype none

module q4dp_front
  import q4dp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         a_byte_i,
  input  wire logic [7:0]         b_byte_i,
  input  wire logic signed [15:0] a_scale_i,
  input  wire logic signed [15:0] b_scale_i,
  input  wire logic               last_in_block_i,
  input  wire logic               last_in_row_i,
  output logic                    entry_valid_o,
  output blk_entry_t              entry_o
);

  logic signed [12:0] block_sum_q, block_sum_d;
  logic signed [13:0] sum_wide;
  logic signed [12:0] sum_sat;
  logic               close_blk;

  assign sum_wide  = 14'(block_sum_q) + 14'(pair_product(a_byte_i, b_byte_i));
  assign close_blk = last_in_block_i || last_in_row_i;

  always_comb begin
    if (sum_wide > 14'(BSUM_MAX)) begin
      sum_sat = BSUM_MAX;
    end else if (sum_wide < 14'(BSUM_MIN)) begin
      sum_sat = BSUM_MIN;
    end else begin
      sum_sat = sum_wide[12:0];
    end
    block_sum_d = block_sum_q;
    if (accept_i) begin
      block_sum_d = close_blk ? '0 : sum_sat;
    end
  end

  assign entry_valid_o    = accept_i && close_blk;
  assign entry_o.sum      = sum_sat;
  assign entry_o.a_scale  = a_scale_i;
  assign entry_o.b_scale  = b_scale_i;
  assign entry_o.row_end  = last_in_row_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_sum_q <= '0;
    end else begin
      block_sum_q <= block_sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/q4dp_back.sv =====
// Back end: scales each closed block sum and adds it to the saturating row accumulator.
// Sequencer of scale multiply, term multiply and accumulate. Depends on q4dp_pkg.
`default_nettype none

module q4dp_back
  import q4dp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        mid_empty_i,
  input  wire blk_entry_t  mid_entry_i,
  output logic             mid_pop_o,
  input  wire logic        out_full_i,
  output logic             out_push_o,
  output logic [63:0]      out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic signed [12:0] sum_q;
  logic signed [31:0] scale_q;
  logic signed [44:0] term_q;
  logic               row_end_q;
  logic signed [63:0] acc_q, acc_d;
  logic signed [64:0] acc_wide;
  logic signed [63:0] acc_sat;
  logic               acc_go;

  assign acc_wide = 65'(acc_q) + 65'(term_q);

  always_comb begin
    if (acc_wide[64] != acc_wide[63]) begin
      acc_sat = acc_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_sat = acc_wide[63:0];
    end
  end

  assign acc_go     = (state_q == S_ACC) && !(row_end_q && out_full_i);
  assign mid_pop_o  = (state_q == S_IDLE) && !mid_empty_i;
  assign out_push_o = acc_go && row_end_q;
  assign out_data_o = acc_sat;

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    case (state_q)
      S_IDLE: begin
        if (!mid_empty_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (acc_go) begin
          acc_d   = row_end_q ? '0 : acc_sat;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      sum_q     <= mid_entry_i.sum;
      scale_q   <= mid_entry_i.a_scale * mid_entry_i.b_scale;
      row_end_q <= mid_entry_i.row_end;
    end
    if (state_q == S_MUL) begin
      term_q <= sum_q * scale_q;
    end
  end

  a_push_from_acc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> (state_q == S_ACC) && row_end_q)
    else $error("result pushed outside accumulate step");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result pushed into full queue");

  a_pop_then_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop_o |=> (state_q == S_MUL))
    else $error("popped entry not multiplied");

  a_acc_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |=> (acc_q == '0))
    else $error("accumulator not cleared after row end");

endmodule

`default_nettype wire

// ===== src/q4_block_dot_product.sv =====
// Top level of the 4-bit block-quantized dot product; depends on q4dp_pkg,
// q4dp_front, q4dp_fifo and q4dp_back.
// Throughput: one item per cycle while full is low; each block or row end takes the back unit
// through scale multiply, term multiply and accumulate, buffered by a MidDepth queue.
// A row-end item passes the mid queue, those steps and the result queue before it shows.
// Reset clears the block sum, the row accumulator and both queues.
`default_nettype none

module q4_block_dot_product
  import q4dp_pkg::*;
#(
  parameter int unsigned MidDepth = MID_DEPTH,
  parameter int unsigned OutDepth = OUT_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         a_byte_i,
  input  wire logic [7:0]         b_byte_i,
  input  wire logic signed [15:0] a_scale_i,
  input  wire logic signed [15:0] b_scale_i,
  input  wire logic               last_in_block_i,
  input  wire logic               last_in_row_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [63:0]      dot_product_o
);

  logic       accept;
  logic       entry_valid;
  blk_entry_t entry;
  blk_entry_t mid_entry;
  logic       mid_full, mid_empty, mid_pop;
  logic       out_full, out_push;
  logic [63:0] out_data, out_head;

  assign full   = mid_full;
  assign accept = push && !mid_full;

  q4dp_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .a_byte_i,
    .b_byte_i,
    .a_scale_i,
    .b_scale_i,
    .last_in_block_i,
    .last_in_row_i,
    .entry_valid_o   (entry_valid),
    .entry_o         (entry)
  );

  q4dp_fifo #(
    .Width ($bits(blk_entry_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (entry_valid),
    .data_i  (entry),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_entry),
    .empty_o (mid_empty)
  );

  q4dp_back u_back (
    .clk_i,
    .rst_ni,
    .mid_empty_i (mid_empty),
    .mid_entry_i (mid_entry),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_data_o  (out_data)
  );

  q4dp_fifo #(
    .Width (64),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (out_push),
    .data_i  (out_data),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_head),
    .empty_o (empty)
  );

  assign dot_product_o = signed'(out_head);

endmodule

`default_nettype wire
